// ===== rtl/soa_pkg.sv =====
// ----------------------------------------------------------------------------
// soa_pkg: shared types and constants of the slab object allocator
// Sizes, list tags, status codes and controller states.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int unsigned NumSlabs    = 16;
  localparam int unsigned MaxSlots    = 256;
  localparam int unsigned SlabBytes   = 4096;
  localparam int unsigned HeaderBytes = 32;

  localparam int unsigned SlabW = 4;   // slab index bits
  localparam int unsigned LinkW = 5;   // slab index plus null
  localparam int unsigned SlotW = 8;
  localparam int unsigned MemAw = SlabW + SlotW;

  localparam logic [LinkW-1:0] NilSlab = LinkW'(NumSlabs);

  typedef enum logic [1:0] {
    TagUnused  = 2'd0,
    TagEmpty   = 2'd1,
    TagPartial = 2'd2,
    TagFull    = 2'd3
  } tag_e;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StOutOfSlabs = 2'd1,
    StNotFound   = 2'd2,
    StBadFree    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CfgObjectBytes  = 2'd0,
    CfgSlotsPerSlab = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    SIdle, SDecide, SInit, SDiv, SCheck, SRead, SPop, SMove1, SMove2, SOut
  } state_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic latch;      // capture request
    logic sel_head;   // take the partial or empty head and its top slot
    logic take_new;   // start a fresh slab
    logic init_step;  // write one link of a fresh slab
    logic div_start;
    logic div_step;
    logic rd_mem;     // read link and allocated bit of the slot
    logic do_alloc;   // pop slot
    logic do_free;    // push slot
    logic unlink;
    logic push;
    logic fail;       // report the status code in fail_code
    status_e fail_code;
    logic out_load;
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic room_busy;   // slot-room count still running after a size write
    logic is_free;
    logic have_slab;   // partial or empty head present
    logic can_new;
    logic init_done;
    logic div_done;
    logic free_bad_slab;
    logic free_bad_slot;
    logic slot_alloc;
    logic need_move;
  } sts_t;

endpackage

// ===== rtl/soa_ctrl.sv =====
// ----------------------------------------------------------------------------
// soa_ctrl: request sequencer
// Steps one request through slab choice, division, memory access and list moves.
// ----------------------------------------------------------------------------
module soa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            out_busy_i,
  input  soa_pkg::sts_t   sts_i,
  output soa_pkg::cmd_t   cmd_o
);

  soa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= soa_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      soa_pkg::SIdle:   if (in_valid_i && !sts_i.room_busy) state_d = soa_pkg::SDecide;
      soa_pkg::SDecide: begin
        if (sts_i.is_free) begin
          state_d = sts_i.free_bad_slab ? soa_pkg::SOut : soa_pkg::SDiv;
        end else if (sts_i.have_slab) begin
          state_d = soa_pkg::SRead;
        end else if (sts_i.can_new) begin
          state_d = soa_pkg::SInit;
        end else begin
          state_d = soa_pkg::SOut;
        end
      end
      soa_pkg::SInit:   if (sts_i.init_done) state_d = soa_pkg::SRead;
      soa_pkg::SDiv:    if (sts_i.div_done) state_d = soa_pkg::SCheck;
      soa_pkg::SCheck:  state_d = sts_i.free_bad_slot ? soa_pkg::SOut : soa_pkg::SRead;
      soa_pkg::SRead:   state_d = soa_pkg::SPop;
      soa_pkg::SPop: begin
        if (sts_i.is_free && !sts_i.slot_alloc) state_d = soa_pkg::SOut;
        else state_d = soa_pkg::SMove1;
      end
      soa_pkg::SMove1:  state_d = sts_i.need_move ? soa_pkg::SMove2 : soa_pkg::SOut;
      soa_pkg::SMove2:  state_d = soa_pkg::SOut;
      soa_pkg::SOut:    if (!out_busy_i) state_d = soa_pkg::SIdle;
      default:          state_d = soa_pkg::SIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.fail_code = soa_pkg::StOk;
    // hold the input while busy or while the slot room is being counted
    in_stall_o = (state_q != soa_pkg::SIdle) || sts_i.room_busy;
    unique case (state_q)
      soa_pkg::SIdle:   cmd_o.latch = in_valid_i && !sts_i.room_busy;
      soa_pkg::SDecide: begin
        if (sts_i.is_free) begin
          if (sts_i.free_bad_slab) begin
            cmd_o.fail = 1'b1;
            cmd_o.fail_code = soa_pkg::StNotFound;
          end else begin
            cmd_o.div_start = 1'b1;
          end
        end else if (sts_i.have_slab) begin
          cmd_o.sel_head = 1'b1;
        end else if (sts_i.can_new) begin
          cmd_o.take_new = 1'b1;
        end else begin
          cmd_o.fail = 1'b1;
          cmd_o.fail_code = soa_pkg::StOutOfSlabs;
        end
      end
      soa_pkg::SInit:   cmd_o.init_step = 1'b1;
      soa_pkg::SDiv:    cmd_o.div_step = 1'b1;
      soa_pkg::SCheck: begin
        if (sts_i.free_bad_slot) begin
          cmd_o.fail = 1'b1;
          cmd_o.fail_code = soa_pkg::StBadFree;
        end
      end
      soa_pkg::SRead:   cmd_o.rd_mem = 1'b1;
      soa_pkg::SPop: begin
        if (sts_i.is_free) begin
          if (sts_i.slot_alloc) begin
            cmd_o.do_free = 1'b1;
          end else begin
            cmd_o.fail = 1'b1;
            cmd_o.fail_code = soa_pkg::StBadFree;
          end
        end else begin
          cmd_o.do_alloc = 1'b1;
        end
      end
      soa_pkg::SMove1:  cmd_o.unlink = sts_i.need_move;
      soa_pkg::SMove2:  cmd_o.push = 1'b1;
      soa_pkg::SOut:    cmd_o.out_load = !out_busy_i;
      default: ;
    endcase
  end

endmodule

// ===== rtl/soa_divider.sv =====
// ----------------------------------------------------------------------------
// soa_divider: restoring divider
// Divides a 12-bit slab offset by the object size, one quotient bit a cycle on step_i.
// ----------------------------------------------------------------------------
module soa_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        step_i,
  input  logic [11:0] dividend_i,
  input  logic [11:0] divisor_i,
  output logic        done_o,
  output logic [11:0] quot_o,
  output logic [11:0] rem_o
);

  logic [11:0] quot_q, quot_d;
  logic [11:0] rem_q, rem_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [12:0] trial;

  assign trial = {rem_q, quot_q[11]} - {1'b0, divisor_i};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
    end else if (step_i && cnt_q != 4'd12) begin
      if (!trial[12]) begin
        rem_d  = trial[11:0];
        quot_d = {quot_q[10:0], 1'b1};
      end else begin
        rem_d  = {rem_q[10:0], quot_q[11]};
        quot_d = {quot_q[10:0], 1'b0};
      end
      cnt_d = cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 4'd12;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = (cnt_q == 4'd12);
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/soa_datapath.sv =====
// ----------------------------------------------------------------------------
// soa_datapath: slab bookkeeping
// Slab lists, per-slab counters, the free-slot link memory and result register.
// ----------------------------------------------------------------------------
module soa_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [11:0]         cfg_wdata_i,
  input  logic                req_type_i,
  input  logic [15:0]         address_i,
  input  soa_pkg::cmd_t       cmd_i,
  output soa_pkg::sts_t       sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [3:0]          slab_index_o,
  output logic [7:0]          slot_index_o,
  output logic [15:0]         object_address_o
);

  localparam int unsigned SW = soa_pkg::SlabW;
  localparam int unsigned LW = soa_pkg::LinkW;
  localparam int unsigned PW = soa_pkg::SlotW;

  // configuration
  logic [11:0] obj_q;
  logic [7:0]  sps_q;

  // derived sizes
  logic [11:0] size;
  logic [8:0]  slot_n;   // slot count in effect, up to 254

  // list state
  soa_pkg::tag_e     tag_q [soa_pkg::NumSlabs];
  logic [LW-1:0]     nxt_q [soa_pkg::NumSlabs];
  logic [LW-1:0]     prv_q [soa_pkg::NumSlabs];
  logic [PW-1:0]     cnt_q [soa_pkg::NumSlabs];
  logic [PW-1:0]     top_q [soa_pkg::NumSlabs];
  logic [LW-1:0]     full_h_q, part_h_q, empt_h_q;
  logic [LW-1:0]     taken_q;

  // per-slot memories
  logic [PW-1:0] link_mem [2**soa_pkg::MemAw];
  logic          alloc_mem [2**soa_pkg::MemAw];
  logic [PW-1:0] link_rd_q;
  logic          alloc_rd_q;

  // request registers
  logic          is_free_q;
  logic [SW-1:0] slab_q;
  logic [PW-1:0] slot_q;
  logic [PW:0]   init_k_q;
  logic [12:0]   off_rel;
  logic          hdr_miss;
  soa_pkg::tag_e new_tag_q;

  // result
  logic          ov_q;
  logic [1:0]    st_q;
  logic [15:0]   addr_q;
  logic [PW-1:0] ncnt;

  logic        div_done;
  logic [11:0] quot, rem;

  // Room per slab: sizes are >= 16 so at most 254 objects fit; the count runs
  // after an object size write and holds the input.
  logic [11:0] room_rem_q;
  logic [8:0]  room_q;
  logic        room_busy_q;

  assign size = (obj_q < 12'd16) ? 12'd16 : obj_q;

  // Room counter: count how many objects fit by repeated subtraction after a size write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_q       <= 12'd16;
      sps_q       <= 8'd254;
      room_busy_q <= 1'b0;
      room_rem_q  <= 12'(soa_pkg::SlabBytes - soa_pkg::HeaderBytes) - 12'd16 * 12'd254;
      room_q      <= 9'd254;
    end else begin
      if (cfg_we_i && taken_q == '0) begin
        unique case (cfg_idx_i)
          soa_pkg::CfgObjectBytes: begin
            obj_q       <= cfg_wdata_i;
            room_busy_q <= 1'b1;
            room_rem_q  <= 12'(soa_pkg::SlabBytes - soa_pkg::HeaderBytes);
            room_q      <= '0;
          end
          soa_pkg::CfgSlotsPerSlab: sps_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end else if (room_busy_q) begin
        if (room_rem_q >= size) begin
          room_rem_q <= room_rem_q - size;
          room_q     <= room_q + 9'd1;
        end else begin
          room_busy_q <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    logic [8:0] nn;
    nn = (sps_q == '0) ? 9'd1 : {1'b0, sps_q};
    if (nn > 9'(soa_pkg::MaxSlots)) nn = 9'(soa_pkg::MaxSlots);
    if (nn > room_q) nn = room_q;
    slot_n = nn;
  end

  soa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (off_rel[11:0]),
    .divisor_i  (size),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  logic [SW-1:0] addr_slab;
  assign addr_slab = address_i[15:12];
  assign off_rel   = {1'b0, addr_q[11:0]} - 13'(soa_pkg::HeaderBytes);
  assign hdr_miss  = off_rel[12];

  logic [LW-1:0] pick;
  assign pick = (part_h_q != soa_pkg::NilSlab) ? part_h_q : empt_h_q;

  always_comb begin
    sts_o = '0;
    sts_o.room_busy     = room_busy_q;
    sts_o.is_free       = is_free_q;
    sts_o.have_slab     = (pick != soa_pkg::NilSlab);
    sts_o.can_new       = (taken_q != LW'(soa_pkg::NumSlabs)) && (slot_n != '0);
    sts_o.init_done     = (init_k_q >= slot_n);
    sts_o.div_done      = div_done;
    sts_o.free_bad_slab = hdr_miss
                          || (tag_q[slab_q] != soa_pkg::TagFull
                              && tag_q[slab_q] != soa_pkg::TagPartial);
    sts_o.free_bad_slot = (rem != '0) || (quot >= 12'(slot_n));
    sts_o.slot_alloc    = alloc_rd_q;
    sts_o.need_move     = (new_tag_q != tag_q[slab_q]);
  end

  assign ncnt = cnt_q[slab_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step && !(init_k_q >= slot_n)) begin
      link_mem[{slab_q, init_k_q[PW-1:0]}] <= (init_k_q == '0) ? '0
                                             : init_k_q[PW-1:0] - PW'(1);
      alloc_mem[{slab_q, init_k_q[PW-1:0]}] <= 1'b0;
    end else if (cmd_i.do_alloc) begin
      alloc_mem[{slab_q, slot_q}] <= 1'b1;
    end else if (cmd_i.do_free) begin
      link_mem[{slab_q, slot_q}]  <= top_q[slab_q];
      alloc_mem[{slab_q, slot_q}] <= 1'b0;
    end
    if (cmd_i.rd_mem) begin
      link_rd_q  <= link_mem[{slab_q, slot_q}];
      alloc_rd_q <= alloc_mem[{slab_q, slot_q}];
    end
  end

  // unlinked previous/next of the moving slab
  logic [LW-1:0] nx, pv, oh;
  assign nx = nxt_q[slab_q];
  assign pv = prv_q[slab_q];
  always_comb begin
    unique case (new_tag_q)
      soa_pkg::TagFull:    oh = full_h_q;
      soa_pkg::TagPartial: oh = part_h_q;
      default:             oh = empt_h_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < soa_pkg::NumSlabs; i++) begin
        tag_q[i] <= soa_pkg::TagUnused;
        cnt_q[i] <= '0;
      end
      full_h_q  <= soa_pkg::NilSlab;
      part_h_q  <= soa_pkg::NilSlab;
      empt_h_q  <= soa_pkg::NilSlab;
      taken_q   <= '0;
      ov_q      <= 1'b0;
    end else begin
      if (cmd_i.take_new) begin
        // new slab goes straight onto the partial list
        tag_q[taken_q[SW-1:0]] <= soa_pkg::TagPartial;
        cnt_q[taken_q[SW-1:0]] <= '0;
        nxt_q[taken_q[SW-1:0]] <= part_h_q;
        prv_q[taken_q[SW-1:0]] <= soa_pkg::NilSlab;
        part_h_q <= taken_q;
        taken_q  <= taken_q + LW'(1);
      end
      if (cmd_i.do_alloc) begin
        cnt_q[slab_q] <= ncnt + PW'(1);
      end
      if (cmd_i.do_free) begin
        cnt_q[slab_q] <= ncnt - PW'(1);
      end
      if (cmd_i.unlink) begin
        if (pv != soa_pkg::NilSlab) begin
          nxt_q[pv[SW-1:0]] <= nx;
        end else begin
          unique case (tag_q[slab_q])
            soa_pkg::TagFull:    full_h_q <= nx;
            soa_pkg::TagPartial: part_h_q <= nx;
            default:             empt_h_q <= nx;
          endcase
        end
        if (nx != soa_pkg::NilSlab) prv_q[nx[SW-1:0]] <= pv;
      end
      if (cmd_i.push) begin
        nxt_q[slab_q] <= oh;
        prv_q[slab_q] <= soa_pkg::NilSlab;
        if (oh != soa_pkg::NilSlab) prv_q[oh[SW-1:0]] <= {1'b0, slab_q};
        unique case (new_tag_q)
          soa_pkg::TagFull:    full_h_q <= {1'b0, slab_q};
          soa_pkg::TagPartial: part_h_q <= {1'b0, slab_q};
          default:             empt_h_q <= {1'b0, slab_q};
        endcase
        tag_q[slab_q] <= new_tag_q;
      end
      if (cmd_i.out_load) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;
    end
  end

  // request and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      is_free_q <= req_type_i;
      addr_q    <= address_i;
      slab_q    <= addr_slab;
      st_q      <= soa_pkg::StOk;
      init_k_q  <= '0;
    end
    if (cmd_i.fail) st_q <= cmd_i.fail_code;
    if (cmd_i.sel_head) begin
      slab_q <= pick[SW-1:0];
      slot_q <= top_q[pick[SW-1:0]];
    end
    if (cmd_i.take_new) begin
      slab_q <= taken_q[SW-1:0];
      slot_q <= 8'(slot_n - 9'd1);
      top_q[taken_q[SW-1:0]] <= 8'(slot_n - 9'd1);
    end
    if (cmd_i.init_step && !(init_k_q >= slot_n)) init_k_q <= init_k_q + 9'd1;
    if (cmd_i.div_step && div_done) slot_q <= quot[PW-1:0];
    if (cmd_i.do_alloc) begin
      top_q[slab_q] <= link_rd_q;
      if (9'(ncnt) + 9'd1 == slot_n) new_tag_q <= soa_pkg::TagFull;
      else new_tag_q <= soa_pkg::TagPartial;
    end
    if (cmd_i.do_free) begin
      top_q[slab_q] <= slot_q;
      if (ncnt == PW'(1)) new_tag_q <= soa_pkg::TagEmpty;
      else new_tag_q <= soa_pkg::TagPartial;
    end
    if (cmd_i.out_load) begin
      status_o         <= st_q;
      slab_index_o     <= (st_q == soa_pkg::StOk) ? slab_q : '0;
      slot_index_o     <= (st_q == soa_pkg::StOk) ? slot_q : '0;
      object_address_o <= (st_q == soa_pkg::StOk)
                          ? ({slab_q, 12'd0} + 16'(soa_pkg::HeaderBytes)
                             + 16'(slot_q) * 16'(size))
                          : '0;
    end
  end

  assign out_valid_o = ov_q;

endmodule

// ===== rtl/slab_object_allocator_unit.sv =====
// An allocate from a listed slab pops its top slot; a list move follows when the slab
// changes list, and a fresh slab first writes one link per slot. A free runs the offset
// divider; a double free fails after the slot read, a misaligned or out-of-range free
// after the divider, and a rejected slab or out of slabs in the decision step.
// One request in flight; the next is accepted only once the result has loaded.
// Reset empties all lists; an object size write holds the input while the room is counted.
// ----------------------------------------------------------------------------
// slab_object_allocator_unit: slab allocator for fixed-size objects
// Sequencer and bookkeeping datapath behind valid/stall channels.
// ----------------------------------------------------------------------------
module slab_object_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [15:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  slab_index_o,
  output logic [7:0]  slot_index_o,
  output logic [15:0] object_address_o
);

  soa_pkg::cmd_t cmd;
  soa_pkg::sts_t sts;

  soa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_busy_i (out_valid_o && out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  soa_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (req_type_i),
    .address_i        (address_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .slab_index_o     (slab_index_o),
    .slot_index_o     (slot_index_o),
    .object_address_o (object_address_o)
  );

endmodule

// ===== tb/tb_slab_object_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_slab_object_allocator_unit: self-checking bench of the slab allocator
// Drives allocate and free requests with random idling on both channels and
// checks every result against a bookkeeping predictor of the slab lists or a fixed expectation.
// ----------------------------------------------------------------------------
module tb_slab_object_allocator_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  typedef struct packed {
    soa_pkg::status_e status;
    logic [3:0]       slab;
    logic [7:0]       slot;
    logic [15:0]      addr;
  } alloc_result_t;

  typedef struct {
    logic          req;
    logic [15:0]   addr;
    bit            typed;
    alloc_result_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [11:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic [15:0] address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  slab_index_o;
  logic [7:0]  slot_index_o;
  logic [15:0] object_address_o;

  slab_object_allocator_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  logic [11:0]   obj_bytes_q;
  logic [7:0]    slots_cfg_q;
  soa_pkg::tag_e slab_tag [soa_pkg::NumSlabs];
  int unsigned   slab_nxt [soa_pkg::NumSlabs];
  int unsigned   slab_prv [soa_pkg::NumSlabs];
  int unsigned   full_head, partial_head, empty_head, taken;
  int unsigned   in_use [soa_pkg::NumSlabs];
  int unsigned   stack_top [soa_pkg::NumSlabs];
  int unsigned   slot_link [soa_pkg::NumSlabs*soa_pkg::MaxSlots];
  bit            slot_busy [soa_pkg::NumSlabs*soa_pkg::MaxSlots];

  alloc_result_t pending_results[$];
  logic [15:0]   live_addrs[$];
  logic [15:0]   freed_addrs[$];
  int unsigned   errors = 0;
  int unsigned   cycles = 0;
  bit            quiet = 1'b0;
  int unsigned   stall_burst = 0;

  function automatic int unsigned eff_obj_bytes();
    return (obj_bytes_q < 16) ? 16 : 32'(obj_bytes_q);
  endfunction

  function automatic int unsigned slots_in_slab();
    int unsigned n, room;
    n = (slots_cfg_q == 0) ? 1 : 32'(slots_cfg_q);
    room = (soa_pkg::SlabBytes - soa_pkg::HeaderBytes) / eff_obj_bytes();
    if (n > soa_pkg::MaxSlots) n = soa_pkg::MaxSlots;
    if (n > room) n = room;
    return n;
  endfunction

  function automatic int unsigned head_get(soa_pkg::tag_e t);
    case (t)
      soa_pkg::TagFull:    return full_head;
      soa_pkg::TagPartial: return partial_head;
      default:             return empty_head;
    endcase
  endfunction

  function automatic void head_set(soa_pkg::tag_e t, int unsigned v);
    case (t)
      soa_pkg::TagFull:    full_head = v;
      soa_pkg::TagPartial: partial_head = v;
      default:             empty_head = v;
    endcase
  endfunction

  function automatic void list_push(soa_pkg::tag_e t, int unsigned s);
    int unsigned h;
    h = head_get(t);
    slab_nxt[s] = h;
    slab_prv[s] = soa_pkg::NumSlabs;
    if (h < soa_pkg::NumSlabs) slab_prv[h] = s;
    head_set(t, s);
    slab_tag[s] = t;
  endfunction

  function automatic void list_move(soa_pkg::tag_e t, int unsigned s);
    int unsigned nx, pv;
    nx = slab_nxt[s];
    pv = slab_prv[s];
    if (pv < soa_pkg::NumSlabs) slab_nxt[pv] = nx;
    else head_set(slab_tag[s], nx);
    if (nx < soa_pkg::NumSlabs) slab_prv[nx] = pv;
    list_push(t, s);
  endfunction

  function automatic logic [15:0] object_addr(int unsigned s, int unsigned slot);
    return 16'(s * soa_pkg::SlabBytes + soa_pkg::HeaderBytes + slot * eff_obj_bytes());
  endfunction

  function automatic alloc_result_t allocator_step(logic req, logic [15:0] addr);
    alloc_result_t r;
    int unsigned n, s, slot, base, off, rel;
    r = '{soa_pkg::StOk, '0, '0, '0};
    n = slots_in_slab();
    if (req == ReqAlloc) begin
      if (partial_head < soa_pkg::NumSlabs) begin
        s = partial_head;
      end else if (empty_head < soa_pkg::NumSlabs) begin
        s = empty_head;
      end else if (taken < soa_pkg::NumSlabs && n > 0) begin
        s = taken;
        taken++;
        base = s * soa_pkg::MaxSlots;
        for (int k = 0; k < n; k++) begin
          slot_link[base+k] = (k == 0) ? 0 : k - 1;
          slot_busy[base+k] = 1'b0;
        end
        stack_top[s] = n - 1;
        in_use[s] = 0;
        list_push(soa_pkg::TagPartial, s);
      end else begin
        r.status = soa_pkg::StOutOfSlabs;
        return r;
      end
      base = s * soa_pkg::MaxSlots;
      slot = stack_top[s] % soa_pkg::MaxSlots;
      stack_top[s] = slot_link[base+slot];
      slot_busy[base+slot] = 1'b1;
      in_use[s]++;
      if (in_use[s] == n) list_move(soa_pkg::TagFull, s);
      else if (in_use[s] == 1) list_move(soa_pkg::TagPartial, s);
    end else begin
      s = addr / soa_pkg::SlabBytes;
      off = addr % soa_pkg::SlabBytes;
      if (s >= soa_pkg::NumSlabs || off < soa_pkg::HeaderBytes ||
          (slab_tag[s] != soa_pkg::TagFull && slab_tag[s] != soa_pkg::TagPartial)) begin
        r.status = soa_pkg::StNotFound;
        return r;
      end
      rel = off - soa_pkg::HeaderBytes;
      slot = rel / eff_obj_bytes();
      base = s * soa_pkg::MaxSlots;
      if (rel % eff_obj_bytes() != 0 || slot >= n || !slot_busy[base+slot]) begin
        r.status = soa_pkg::StBadFree;
        return r;
      end
      slot_link[base+slot] = stack_top[s];
      stack_top[s] = slot;
      slot_busy[base+slot] = 1'b0;
      in_use[s]--;
      if (in_use[s] == 0) list_move(soa_pkg::TagEmpty, s);
      else if (in_use[s] + 1 == n) list_move(soa_pkg::TagPartial, s);
    end
    r.slab = 4'(s);
    r.slot = 8'(slot);
    r.addr = object_addr(s, slot);
    return r;
  endfunction

  // Track live objects so that frees mostly hit real allocations
  function automatic void track_objects(logic req, alloc_result_t r);
    if (r.status != soa_pkg::StOk) return;
    if (req == ReqAlloc) begin
      live_addrs.push_back(r.addr);
    end else begin
      foreach (live_addrs[i])
        if (live_addrs[i] == r.addr) begin
          live_addrs.delete(i);
          break;
        end
      freed_addrs.push_back(r.addr);
      if (freed_addrs.size() > 8) void'(freed_addrs.pop_front());
    end
  endfunction

  task automatic send_request(logic req, logic [15:0] addr, bit typed, alloc_result_t typed_res);
    alloc_result_t r;
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    req_type_i = req;
    address_i  = addr;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = allocator_step(req, addr);
    track_objects(req, r);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  task automatic write_register(soa_pkg::cfg_idx_e idx, logic [11:0] val);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    // let the final request finish its list updates
    repeat (30) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (taken == 0) begin
      if (idx == soa_pkg::CfgObjectBytes) obj_bytes_q = val;
      else slots_cfg_q = val[7:0];
    end
    // hold off while the slot-room counter settles
    repeat (300) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_burst != 0) begin
      stall_burst <= stall_burst - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(4) == 0) stall_burst <= $urandom_range(1, 6);
    end
  end

  always @(posedge clk_i) begin
    alloc_result_t e;
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: status %0d addr %0h", status_o, object_address_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, status_o);
          errors++;
        end
        if (slab_index_o !== e.slab) begin
          $error("slab_index: expected %0d, actual %0d", e.slab, slab_index_o);
          errors++;
        end
        if (slot_index_o !== e.slot) begin
          $error("slot_index: expected %0d, actual %0d", e.slot, slot_index_o);
          errors++;
        end
        if (object_address_o !== e.addr) begin
          $error("object_address: expected %0h, actual %0h", e.addr, object_address_o);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t   rows[$];
    stim_row_t   row;
    int unsigned alloc_pct;
    int unsigned pick;
    logic [15:0] addr;
    logic        req;

    obj_bytes_q  = 12'd16;
    slots_cfg_q  = 8'd254;
    full_head    = soa_pkg::NumSlabs;
    partial_head = soa_pkg::NumSlabs;
    empty_head   = soa_pkg::NumSlabs;
    taken        = 0;
    foreach (slab_tag[i]) begin
      slab_tag[i] = soa_pkg::TagUnused;
      in_use[i] = 0;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Sweep the extremes, then settle on 300-byte objects, 13 to a slab
    write_register(soa_pkg::CfgObjectBytes, 12'd16);
    write_register(soa_pkg::CfgSlotsPerSlab, 12'd255);
    write_register(soa_pkg::CfgObjectBytes, 12'd4064);
    write_register(soa_pkg::CfgSlotsPerSlab, 12'd0);
    write_register(soa_pkg::CfgObjectBytes, 12'd300);
    write_register(soa_pkg::CfgSlotsPerSlab, 12'd255);

    rows.push_back('{ReqFree,  16'h0000, 1, '{soa_pkg::StNotFound, 4'd0, 8'd0, 16'd0}});
    rows.push_back('{ReqFree,  16'hFFFF, 1, '{soa_pkg::StNotFound, 4'd0, 8'd0, 16'd0}});
    rows.push_back('{ReqAlloc, 16'hFFFF, 1, '{soa_pkg::StOk, 4'd0, 8'd12, 16'd3632}});
    rows.push_back('{ReqAlloc, 16'h0000, 1, '{soa_pkg::StOk, 4'd0, 8'd11, 16'd3332}});
    rows.push_back('{ReqFree,  16'd3632, 1, '{soa_pkg::StOk, 4'd0, 8'd12, 16'd3632}});
    rows.push_back('{ReqFree,  16'd3632, 1, '{soa_pkg::StBadFree, 4'd0, 8'd0, 16'd0}});
    rows.push_back('{ReqFree,  16'd3333, 1, '{soa_pkg::StBadFree, 4'd0, 8'd0, 16'd0}});
    rows.push_back('{ReqFree,  16'd3932, 1, '{soa_pkg::StBadFree, 4'd0, 8'd0, 16'd0}});
    rows.push_back('{ReqFree,  16'h1020, 1, '{soa_pkg::StNotFound, 4'd0, 8'd0, 16'd0}});
    // fill slab 0 and spill into slab 1
    repeat (14) rows.push_back('{ReqAlloc, 16'h0000, 0, '0});
    rows.push_back('{ReqFree,  16'd32,   0, '0});
    rows.push_back('{ReqFree,  16'h001F, 1, '{soa_pkg::StNotFound, 4'd0, 8'd0, 16'd0}});
    foreach (rows[i]) begin
      row = rows[i];
      send_request(row.req, row.addr, row.typed, row.res);
    end

    // Alloc-heavy and free-heavy phases; writes mid-run must be ignored
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 3) write_register(soa_pkg::CfgObjectBytes, 12'd4064);
      if (phase == 5) write_register(soa_pkg::CfgSlotsPerSlab, 12'd1);
      if (phase == 7) quiet = 1'b1;
      alloc_pct = (phase < 4 || phase == 6) ? 85 : 25;
      for (int k = 0; k < 100; k++) begin
        req = ($urandom_range(99) < alloc_pct) ? ReqAlloc : ReqFree;
        addr = 16'($urandom);
        if (req == ReqFree) begin
          pick = $urandom_range(9);
          if (pick < 7 && live_addrs.size() != 0)
            addr = live_addrs[$urandom_range(live_addrs.size() - 1)];
          else if (pick == 7 && freed_addrs.size() != 0)
            addr = freed_addrs[$urandom_range(freed_addrs.size() - 1)];
          else if (pick == 8 && live_addrs.size() != 0)
            addr = 16'(live_addrs[$urandom_range(live_addrs.size() - 1)]
                       + $urandom_range(1, 299));
        end
        send_request(req, addr, 1'b0, '0);
      end
    end

    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
